>>> src/earliest_free_worker_dispatch_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the earliest-free worker dispatch unit
// Immediate-implication and next-cycle checks, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_WORKER_DISPATCH_UNIT_DEFINES_SVH
`define EARLIEST_FREE_WORKER_DISPATCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define EFW_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
`define EFW_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define EFW_ASSERT_NOW(label, pre, post)
`define EFW_ASSERT_NEXT(label, pre, post)
`endif
`endif

>>> src/efw_pkg.sv
// ----------------------------------------------------------------------------
// efw_pkg
// Shared types and constants for the earliest-free worker dispatch unit.
// ----------------------------------------------------------------------------
package efw_pkg;
  localparam int TIME_W = 48;
  localparam int DUR_W  = 32;
  localparam int ID_W   = 4;
  localparam int CNT_W  = 5;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE
  } efw_state_t;
endpackage

>>> src/efw_ram.sv
// ----------------------------------------------------------------------------
// efw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module efw_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/earliest_free_worker_dispatch_unit.sv
// Flow: an accepted job steps through ST_SCAN, ST_DRAIN and ST_UPDATE, and done is
// high in ST_UPDATE; busy holds off a new job until ST_IDLE. The scan reads one free
// time per cycle from the single read port of the free-time RAM.
// done is a one-cycle strobe; the receiver cannot stall.
// Reset: synchronous, clears all free times (via valid bits) and sets count to 16.
// ----------------------------------------------------------------------------
// earliest_free_worker_dispatch_unit
// Assigns each job to the earliest-free worker and advances its free time.
// ----------------------------------------------------------------------------
`include "earliest_free_worker_dispatch_unit_defines.svh"
module earliest_free_worker_dispatch_unit
  import efw_pkg::*;
#(
  parameter int MAX_WORKERS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [DUR_W-1:0]  job_duration,
  output logic              done,
  output logic [ID_W-1:0]   worker_id,
  output logic [TIME_W-1:0] start_time,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata
);
  localparam int AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int XW = (AW > 9) ? AW : 9;

  efw_state_t state, state_next;
  logic [CNT_W-1:0]      worker_count;
  logic [DUR_W-1:0]      dur;
  logic [AW-1:0]         last_idx;
  logic [AW-1:0]         idx;
  logic                  dv;
  logic [AW-1:0]         dv_idx;
  logic [AW-1:0]         best_id;
  logic [TIME_W-1:0]     best_time;
  logic [MAX_WORKERS-1:0] vld;
  logic [TIME_W-1:0]     rdata;
  logic [TIME_W-1:0]     rd_val;
  logic [TIME_W:0]       sum;
  logic [TIME_W-1:0]     next_time;
  logic [XW-1:0]         cnt_eff;
  logic [XW-1:0]         id_ext;
  logic                  accept;
  logic                  ram_we;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_UPDATE);
  assign ram_we = done;

  // clamp count to 1..MAX_WORKERS
  always_comb begin
    cnt_eff = XW'(worker_count);
    if (cnt_eff == '0) cnt_eff = XW'(1);
    if (cnt_eff > XW'(MAX_WORKERS)) cnt_eff = XW'(MAX_WORKERS);
  end

  assign rd_val = vld[dv_idx] ? rdata : '0;
  assign sum = {1'b0, best_time} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur};
  assign next_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign id_ext = XW'(best_id);
  assign worker_id = id_ext[ID_W-1:0];
  assign start_time = best_time;

  efw_ram #(.WIDTH(TIME_W), .DEPTH(MAX_WORKERS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (best_id),
    .wdata (next_time),
    .raddr (idx),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_SCAN;
      ST_SCAN:   if (idx == last_idx) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      worker_count <= CNT_RESET;
      vld          <= '0;
      dv           <= 1'b0;
      idx          <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) worker_count <= cfg_wdata;
      dv <= (state == ST_SCAN);
      if (accept) begin
        idx <= '0;
      end else if (state == ST_SCAN && idx != last_idx) begin
        idx <= idx + AW'(1);
      end
      if (ram_we) vld[best_id] <= 1'b1;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      dur      <= job_duration;
      last_idx <= AW'(cnt_eff - XW'(1));
    end
    dv_idx <= idx;
    // strict compare keeps the lowest id on ties
    if (dv && (dv_idx == '0 || rd_val < best_time)) begin
      best_time <= rd_val;
      best_id   <= dv_idx;
    end
  end

  `EFW_ASSERT_NEXT(a_accept_busy, accept, busy)
  `EFW_ASSERT_NEXT(a_done_frees, done, !busy)
  `EFW_ASSERT_NOW(a_done_no_scan, done, !dv)
endmodule
